// ===== rtl/sset_pkg.sv =====
// Shared types and codes for the packed set store.
package sset_pkg;

  localparam int VALUE_W = 32;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 8;

  // request codes (the unused code acts as a query)
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/sset_ram.sv =====
// Entry storage: one write port, one read port with registered read data.
module sset_ram
  import sset_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/set_store_insert_remove_lookup_core.sv =====
// Packed set store top level: search, compaction sequencer and result register.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+------------------------
//   request | in  | in_valid / in_stall  | req_type, value
//   result  | out | out_valid / out_stall| status, found, count
//
// One beat is taken at a time. The single memory read port streams the linear
// search over the stored entries, and on a remove hit the shift of later entries
// picks up where the search stopped. The next request is taken in the cycle
// after the result is loaded.
// Reset (rst, synchronous) empties the store; memory contents are not cleared.
// A stalled result is held in its register; the next request waits until the
// result register can take its beat.
module set_store_insert_remove_lookup_core
  import sset_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [REQ_W-1:0]          req_type,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STAT_W-1:0]         status,
  output logic                      found,
  output logic [COUNT_W-1:0]        count
);

  localparam int AW = $clog2(CAPACITY);

  state_t state, state_next;

  logic [AW-1:0]      entry_count;
  logic [AW-1:0]      idx;
  logic               chk;
  logic [AW-1:0]      chk_idx;
  logic               hit;
  logic [REQ_W-1:0]   req_q;
  logic [VALUE_W-1:0] val_q;

  logic               rd_en, wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data, rd_data;

  logic               more, hit_now, out_free, load, full;
  logic [STAT_W-1:0]  status_next;
  logic [AW-1:0]      count_next;
  logic [AW+COUNT_W-1:0] count_ext;

  sset_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // status terms
  assign more     = idx < entry_count;
  assign hit_now  = (state == S_SEARCH) && chk && (rd_data == val_q);
  assign out_free = !out_valid || !out_stall;
  assign full     = entry_count >= AW'(CAPACITY - 1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (hit_now) begin
          state_next = (req_q == REQ_REMOVE) ? S_SHIFT : S_FINISH;
        end else if (!more && !chk) begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (!more && !chk) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = entry_count;
    wr_data  = val_q;
    load     = 1'b0;
    unique case (state)
      S_IDLE:   in_stall = 1'b0;
      S_SEARCH: rd_en = more && !hit_now;
      S_SHIFT: begin
        rd_en = more;
        // move the entry read last cycle one place down
        if (chk) begin
          wr_en   = 1'b1;
          wr_addr = chk_idx - AW'(1);
          wr_data = rd_data;
        end
      end
      S_FINISH: begin
        load  = out_free;
        wr_en = out_free && (req_q == REQ_INSERT) && !full;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // result of the request being finished
  always_comb begin
    status_next = ST_OK;
    count_next  = entry_count;
    unique case (req_q)
      REQ_INSERT: begin
        if (full) status_next = ST_FULL;
        else      count_next  = entry_count + AW'(1);
      end
      REQ_REMOVE: begin
        if (!hit) status_next = ST_NOT_FOUND;
        else      count_next  = entry_count - AW'(1);
      end
      default: status_next = ST_OK;
    endcase
  end

  assign count_ext = (AW + COUNT_W)'(count_next);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
      chk         <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        entry_count <= count_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:   chk <= 1'b0;
        S_SEARCH: chk <= hit_now ? 1'b0 : rd_en;
        S_SHIFT:  chk <= rd_en;
        S_FINISH: chk <= 1'b0;
        default:  chk <= 1'b0;
      endcase
    end
  end

  // search and shift datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_q <= req_type;
          val_q <= value;
          idx   <= '0;
          hit   <= 1'b0;
        end
      end
      S_SEARCH: begin
        if (hit_now) begin
          hit <= 1'b1;
          idx <= chk_idx + AW'(1);
        end else begin
          chk_idx <= idx;
          if (rd_en) idx <= idx + AW'(1);
        end
      end
      S_SHIFT: begin
        chk_idx <= idx;
        if (rd_en) idx <= idx + AW'(1);
      end
      S_FINISH: begin
        if (load) begin
          status <= status_next;
          found  <= hit;
          count  <= count_ext[COUNT_W-1:0];
        end
      end
      default: idx <= idx;
    endcase
  end

endmodule

// ===== tb/tb_set_store_insert_remove_lookup_core.sv =====
// Self-checking testbench for the packed set store: directed table, then random episodes.
module tb_set_store_insert_remove_lookup_core;
  import sset_pkg::*;

  localparam int CAPACITY = 128;
  localparam int RANDOM_ITEMS = 1626;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 32;
  localparam longint LIMIT_CYCLES = 4_000_000;

  // unused request code, treated as a query by the block
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic [VALUE_W-1:0] V_MAX  = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] V_MIN  = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] V_NEG1 = 32'hffff_ffff;
  localparam logic [VALUE_W-1:0] V_AAAA = 32'haaaa_aaaa;
  localparam logic [VALUE_W-1:0] V_5555 = 32'h5555_5555;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } reply_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [VALUE_W-1:0] val;
    reply_t             reply;
  } directed_row_t;

  // Directed table: empty store, extremes, duplicates, first-match remove,
  // remove of first and last entry, misses, unused request code.
  localparam directed_row_t DIRECTED [24] = '{
    '{REQ_QUERY,  32'd0,  '{ST_OK,        1'b0, 8'd0}},
    '{REQ_REMOVE, 32'd5,  '{ST_NOT_FOUND, 1'b0, 8'd0}},
    '{REQ_INSERT, V_MAX,  '{ST_OK,        1'b0, 8'd1}},
    '{REQ_INSERT, V_MIN,  '{ST_OK,        1'b0, 8'd2}},
    '{REQ_INSERT, V_MIN,  '{ST_OK,        1'b1, 8'd3}},
    '{REQ_QUERY,  V_MIN,  '{ST_OK,        1'b1, 8'd3}},
    '{REQ_UNUSED, V_MAX,  '{ST_OK,        1'b1, 8'd3}},
    '{REQ_INSERT, 32'd0,  '{ST_OK,        1'b0, 8'd4}},
    '{REQ_INSERT, V_NEG1, '{ST_OK,        1'b0, 8'd5}},
    '{REQ_REMOVE, V_MAX,  '{ST_OK,        1'b1, 8'd4}},
    '{REQ_QUERY,  V_MAX,  '{ST_OK,        1'b0, 8'd4}},
    '{REQ_REMOVE, V_MIN,  '{ST_OK,        1'b1, 8'd3}},
    '{REQ_QUERY,  V_MIN,  '{ST_OK,        1'b1, 8'd3}},
    '{REQ_REMOVE, V_NEG1, '{ST_OK,        1'b1, 8'd2}},
    '{REQ_REMOVE, V_NEG1, '{ST_NOT_FOUND, 1'b0, 8'd2}},
    '{REQ_UNUSED, V_5555, '{ST_OK,        1'b0, 8'd2}},
    '{REQ_INSERT, V_AAAA, '{ST_OK,        1'b0, 8'd3}},
    '{REQ_INSERT, V_5555, '{ST_OK,        1'b0, 8'd4}},
    '{REQ_REMOVE, 32'd0,  '{ST_OK,        1'b1, 8'd3}},
    '{REQ_REMOVE, V_MIN,  '{ST_OK,        1'b1, 8'd2}},
    '{REQ_REMOVE, V_AAAA, '{ST_OK,        1'b1, 8'd1}},
    '{REQ_REMOVE, V_5555, '{ST_OK,        1'b1, 8'd0}},
    '{REQ_QUERY,  V_5555, '{ST_OK,        1'b0, 8'd0}},
    '{REQ_REMOVE, 32'd0,  '{ST_NOT_FOUND, 1'b0, 8'd0}}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [REQ_W-1:0]   req_type = '0;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STAT_W-1:0]  status;
  logic               found;
  logic [COUNT_W-1:0] count;

  // shadow copy of the store
  logic [VALUE_W-1:0] set_words [CAPACITY];
  int                 set_count = 0;

  reply_t pending_replies [$];
  int     mismatch_count = 0;
  longint cycle_count = 0;
  int     send_gap_pct = 0;
  int     stall_pct = 0;

  set_store_insert_remove_lookup_core #(.CAPACITY(CAPACITY)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .found     (found),
    .count     (count)
  );

  always #4 clk = ~clk;

  // Apply one request to the shadow store and return the reply it gives.
  function automatic reply_t apply_set_request(logic [REQ_W-1:0] req, logic [VALUE_W-1:0] v);
    reply_t r;
    int     hit_pos;
    hit_pos = -1;
    for (int i = 0; i < set_count; i++) begin
      if (hit_pos < 0 && set_words[i] == v) hit_pos = i;
    end
    r.status = ST_OK;
    r.found  = (hit_pos >= 0);
    if (req == REQ_INSERT) begin
      if (set_count >= CAPACITY - 1) begin
        r.status = ST_FULL;
      end else begin
        set_words[set_count] = v;
        set_count++;
      end
    end else if (req == REQ_REMOVE) begin
      if (hit_pos < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        // close the gap left by the first match
        for (int j = hit_pos; j < set_count - 1; j++) set_words[j] = set_words[j + 1];
        set_count--;
      end
    end
    r.count = COUNT_W'(set_count);
    return r;
  endfunction

  // Stored entry when a hit is wanted, else extremes, a narrow band or anything.
  function automatic logic [VALUE_W-1:0] pick_value(bit want_hit);
    if (want_hit && set_count > 0) return set_words[$urandom_range(0, set_count - 1)];
    case ($urandom_range(0, 9))
      0: return V_MIN;
      1: return V_MAX;
      2, 3, 4, 5: return VALUE_W'($signed($urandom_range(0, 23)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Drive one request beat; record its reply once the beat is taken.
  task automatic send_beat(logic [REQ_W-1:0] req, logic [VALUE_W-1:0] v,
                           bit typed, reply_t typed_reply);
    reply_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    value    <= v;
    do @(posedge clk); while (in_stall);
    predicted = apply_set_request(req, v);
    pending_replies.push_back(typed ? typed_reply : predicted);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // result beat check
  always @(posedge clk) begin : check_beat
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          mismatch_count++;
        end
        if (found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, found);
          mismatch_count++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, count);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int               sent;
    int               phase;
    int               new_phase;
    int               mode;
    int               ep_len;
    int               insert_pct;
    int               remove_pct;
    int               pick;
    logic [REQ_W-1:0] rq;
    logic [VALUE_W-1:0] v;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_beat(DIRECTED[i].req, DIRECTED[i].val, 1'b1, DIRECTED[i].reply);

    // Random episodes: fill (runs into the full store), drain, mixed.
    sent  = 0;
    phase = 0;
    mode  = 0;
    while (sent < RANDOM_ITEMS) begin
      ep_len = (mode == 0) ? $urandom_range(170, 230) : $urandom_range(30, 120);
      case (mode)
        0: begin insert_pct = 92; remove_pct = 4; end
        1: begin insert_pct = 10; remove_pct = 80; end
        default: begin insert_pct = 40; remove_pct = 35; end
      endcase
      for (int k = 0; k < ep_len && sent < RANDOM_ITEMS; k++) begin
        new_phase = sent * 4 / RANDOM_ITEMS;
        if (new_phase != phase) begin
          // hold off until every reply is in, then change the idling mix
          phase = new_phase;
          @(negedge clk);
          in_valid <= 1'b0;
          while (pending_replies.size() != 0) @(negedge clk);
          case (phase)
            1: begin send_gap_pct = 54; stall_pct = 0; end
            2: begin send_gap_pct = 0; stall_pct = 54; end
            default: begin send_gap_pct = 8; stall_pct = 8; end
          endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < insert_pct) begin
          rq = REQ_INSERT;
          v  = pick_value($urandom_range(0, 9) == 0);
        end else if (pick < insert_pct + remove_pct) begin
          rq = REQ_REMOVE;
          v  = pick_value($urandom_range(0, 99) < 75);
        end else begin
          rq = ($urandom_range(0, 3) == 0) ? REQ_UNUSED : REQ_QUERY;
          v  = pick_value($urandom_range(0, 1) == 1);
        end
        send_beat(rq, v, 1'b0, '0);
        sent++;
      end
      mode = $urandom_range(0, 2);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_replies.size() != 0) begin
      $error("%0d replies never arrived", pending_replies.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sset_pkg.sv
rtl/sset_ram.sv
rtl/set_store_insert_remove_lookup_core.sv
tb/tb_set_store_insert_remove_lookup_core.sv
